// ===== sv/kvlp_pkg.sv =====
// kvlp_pkg: shared types, character constants and class functions
// for the key/value line parser; no dependencies
package kvlp_pkg;

    localparam int KEY_VALUE_MAX_DEF = 32;
    localparam int LINE_W            = 16;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;

    localparam logic [LINE_W-1:0] LINE_FIRST = 16'd1;
    localparam logic [LINE_W-1:0] LINE_MAX   = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_WAIT_KEY   = 3'd0,
        MODE_COMMENT    = 3'd1,
        MODE_READ_KEY   = 3'd2,
        MODE_WAIT_EQ    = 3'd3,
        MODE_WAIT_VALUE = 3'd4,
        MODE_READ_VALUE = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_PAIR  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_EXPECTED_KEY   = 3'd0,
        ERR_NEWLINE_IN_KEY = 3'd1,
        ERR_BAD_KEY_CHAR   = 3'd2,
        ERR_KEY_TOO_LONG   = 3'd3,
        ERR_EXPECTED_EQ    = 3'd4,
        ERR_EXPECTED_VALUE = 3'd5,
        ERR_VALUE_TOO_LONG = 3'd6
    } err_t;

    typedef struct packed {
        logic              vld;
        kind_t             kind;
        logic [7:0]        data;
        err_t              code;
        logic [LINE_W-1:0] line;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    endfunction

endpackage

// ===== sv/kvlp_step.sv =====
// kvlp_step: combinational parse step, one byte against the current state
// depends on kvlp_pkg
module kvlp_step #(
    parameter int KEY_VALUE_MAX = kvlp_pkg::KEY_VALUE_MAX_DEF,
    parameter int CNT_W         = $clog2(KEY_VALUE_MAX - 1)
) (
    input  logic [7:0]                    ch,
    input  kvlp_pkg::mode_t               mode,
    input  logic [CNT_W-1:0]              key_cnt,
    input  logic [CNT_W-1:0]              val_cnt,
    input  logic [kvlp_pkg::LINE_W-1:0]   line_cnt,
    input  logic                          failed,
    output kvlp_pkg::mode_t               mode_next,
    output logic [CNT_W-1:0]              key_cnt_next,
    output logic [CNT_W-1:0]              val_cnt_next,
    output logic [kvlp_pkg::LINE_W-1:0]   line_cnt_next,
    output logic                          failed_next,
    output kvlp_pkg::result_t             res
);
    import kvlp_pkg::*;

    localparam logic [CNT_W:0] LIMIT = (CNT_W+1)'(KEY_VALUE_MAX - 2);

    logic [CNT_W:0]        key_inc;
    logic [CNT_W:0]        val_inc;
    logic [LINE_W-1:0]     line_bump;

    assign key_inc   = {1'b0, key_cnt} + 1'b1;
    assign val_inc   = {1'b0, val_cnt} + 1'b1;
    assign line_bump = (line_cnt == LINE_MAX) ? line_cnt : line_cnt + 1'b1;

    always_comb
    begin
        mode_next     = mode;
        key_cnt_next  = key_cnt;
        val_cnt_next  = val_cnt;
        line_cnt_next = line_cnt;
        failed_next   = failed;
        res.vld       = 1'b0;
        res.kind      = KIND_KEY;
        res.data      = 8'd0;
        res.code      = ERR_EXPECTED_KEY;
        res.line      = line_cnt;

        if (!failed)
        begin
            unique case (mode)
                MODE_COMMENT:
                begin
                    if (ch == CH_NEWLINE)
                    begin
                        mode_next     = MODE_WAIT_KEY;
                        line_cnt_next = line_bump;
                    end
                end
                MODE_READ_KEY:
                begin
                    priority if (ch == CH_EQUALS)
                        mode_next = MODE_WAIT_VALUE;
                    else if (is_space(ch))
                        mode_next = MODE_WAIT_EQ;
                    else if (ch == CH_NEWLINE)
                    begin
                        res.vld = 1'b1; res.kind = KIND_ERROR;
                        res.code = ERR_NEWLINE_IN_KEY; failed_next = 1'b1;
                    end
                    else if (!is_letter(ch) && !is_digit(ch))
                    begin
                        res.vld = 1'b1; res.kind = KIND_ERROR;
                        res.code = ERR_BAD_KEY_CHAR; failed_next = 1'b1;
                    end
                    else
                    begin
                        key_cnt_next = key_inc[CNT_W-1:0];
                        res.vld      = 1'b1;
                        if (key_inc == LIMIT)
                        begin
                            res.kind = KIND_ERROR; res.code = ERR_KEY_TOO_LONG;
                            failed_next = 1'b1;
                        end
                        else
                            res.data = ch;
                    end
                end
                MODE_WAIT_EQ:
                begin
                    if (ch == CH_EQUALS)
                        mode_next = MODE_WAIT_VALUE;
                    else if (!is_space(ch))
                    begin
                        res.vld = 1'b1; res.kind = KIND_ERROR;
                        res.code = ERR_EXPECTED_EQ; failed_next = 1'b1;
                    end
                end
                MODE_WAIT_VALUE:
                begin
                    if (is_letter(ch) || is_digit(ch))
                    begin
                        mode_next    = MODE_READ_VALUE;
                        val_cnt_next = val_inc[CNT_W-1:0];
                        res.vld      = 1'b1;
                        if (val_inc == LIMIT)
                        begin
                            res.kind = KIND_ERROR; res.code = ERR_VALUE_TOO_LONG;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            res.kind = KIND_VALUE; res.data = ch;
                        end
                    end
                    else if (!is_space(ch))
                    begin
                        res.vld = 1'b1; res.kind = KIND_ERROR;
                        res.code = ERR_EXPECTED_VALUE; failed_next = 1'b1;
                    end
                end
                MODE_READ_VALUE:
                begin
                    res.vld = 1'b1;
                    if (ch == CH_NEWLINE)
                    begin
                        mode_next     = MODE_WAIT_KEY;
                        key_cnt_next  = '0;
                        val_cnt_next  = '0;
                        line_cnt_next = line_bump;
                        res.kind      = KIND_PAIR;
                    end
                    else
                    begin
                        val_cnt_next = val_inc[CNT_W-1:0];
                        if (val_inc == LIMIT)
                        begin
                            res.kind = KIND_ERROR; res.code = ERR_VALUE_TOO_LONG;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            res.kind = KIND_VALUE; res.data = ch;
                        end
                    end
                end
                default:
                begin
                    // waiting for key, and any code that names no mode
                    mode_next = MODE_WAIT_KEY;
                    if (ch == CH_HASH)
                        mode_next = MODE_COMMENT;
                    else if (ch == CH_NEWLINE)
                        line_cnt_next = line_bump;
                    else if (is_letter(ch))
                    begin
                        mode_next    = MODE_READ_KEY;
                        key_cnt_next = key_inc[CNT_W-1:0];
                        res.vld      = 1'b1;
                        if (key_inc == LIMIT)
                        begin
                            res.kind = KIND_ERROR; res.code = ERR_KEY_TOO_LONG;
                            failed_next = 1'b1;
                        end
                        else
                            res.data = ch;
                    end
                    else if (!is_space(ch))
                    begin
                        res.vld = 1'b1; res.kind = KIND_ERROR;
                        res.code = ERR_EXPECTED_KEY; failed_next = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

// ===== sv/kvlp_out_slot.sv =====
// kvlp_out_slot: result register on the output channel
// depends on kvlp_pkg
module kvlp_out_slot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  kvlp_pkg::result_t             res,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    data_byte,
    output logic [2:0]                    error_code,
    output logic [kvlp_pkg::LINE_W-1:0]   line_number
);
    import kvlp_pkg::*;

    logic              vld_reg;
    kind_t             kind_reg;
    logic [7:0]        data_reg;
    err_t              code_reg;
    logic [LINE_W-1:0] line_reg;

    assign free = !vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (load)
            vld_reg <= 1'b1;
        else if (out_ready)
            vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            code_reg <= res.code;
            line_reg <= res.line;
        end
    end

    assign out_valid   = vld_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign error_code  = code_reg;
    assign line_number = line_reg;

endmodule

// ===== sv/key_value_line_parser.sv =====
// key_value_line_parser: top level, input register, parse state and result slot
// depends on kvlp_pkg, kvlp_step, kvlp_out_slot
//
//  channel | handshake            | word
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | text_byte
//  output  | out_valid / out_ready| kind, data_byte, error_code, line_number
//
// one byte per cycle unless a result must wait; byte and result are each registered
// the parse step is a single combinational pass between input and result registers
// reset clears the parse state to waiting for key, line one, not failed
// a byte with no result never waits on the output; one with a result
// waits in the input register only while the result slot is full and stalled
module key_value_line_parser #(
    parameter int KEY_VALUE_MAX = kvlp_pkg::KEY_VALUE_MAX_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    kind,
    output logic [7:0]                    data_byte,
    output logic [2:0]                    error_code,
    output logic [kvlp_pkg::LINE_W-1:0]   line_number
);
    import kvlp_pkg::*;

    localparam int CNT_W = $clog2(KEY_VALUE_MAX - 1);

    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  key_cnt_reg, key_cnt_next;
    logic [CNT_W-1:0]  val_cnt_reg, val_cnt_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              failed_reg, failed_next;
    result_t           res;
    logic              slot_free;
    logic              advance;

    assign advance  = in_vld_reg && (!res.vld || slot_free);
    assign in_ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && in_ready)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= text_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_WAIT_KEY;
            key_cnt_reg <= '0;
            val_cnt_reg <= '0;
            line_reg    <= LINE_FIRST;
            failed_reg  <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg    <= mode_next;
            key_cnt_reg <= key_cnt_next;
            val_cnt_reg <= val_cnt_next;
            line_reg    <= line_next;
            failed_reg  <= failed_next;
        end
    end

    kvlp_step #(
        .KEY_VALUE_MAX (KEY_VALUE_MAX),
        .CNT_W         (CNT_W)
    ) u_step (
        .ch            (in_byte_reg),
        .mode          (mode_reg),
        .key_cnt       (key_cnt_reg),
        .val_cnt       (val_cnt_reg),
        .line_cnt      (line_reg),
        .failed        (failed_reg),
        .mode_next     (mode_next),
        .key_cnt_next  (key_cnt_next),
        .val_cnt_next  (val_cnt_next),
        .line_cnt_next (line_next),
        .failed_next   (failed_next),
        .res           (res)
    );

    kvlp_out_slot u_out_slot (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance && res.vld),
        .res         (res),
        .free        (slot_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .error_code  (error_code),
        .line_number (line_number)
    );

endmodule

// ===== dv/kvlp_parse_check.sv =====
`timescale 1ns / 1ps
// kvlp_parse_check: watches both channels of the key/value line parser, predicts
// each result word from the accepted text bytes and compares field by field
// depends on kvlp_pkg
module kvlp_parse_check #(
    parameter int KEY_VALUE_MAX = kvlp_pkg::KEY_VALUE_MAX_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  text_byte,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [1:0]                  kind,
    input  logic [7:0]                  data_byte,
    input  logic [2:0]                  error_code,
    input  logic [kvlp_pkg::LINE_W-1:0] line_number,
    output int                          mismatches,
    output int                          words_due
);

    import kvlp_pkg::*;

    typedef enum logic [1:0] {
        CC_LETTER,
        CC_DIGIT,
        CC_BLANK,
        CC_OTHER
    } char_class_t;

    typedef struct {
        kind_t             kind;
        logic [7:0]        data;
        err_t              code;
        logic [LINE_W-1:0] line;
    } parse_word_t;

    mode_t             mode;
    logic [7:0]        key_len;
    logic [7:0]        val_len;
    logic [LINE_W-1:0] line_no;
    logic              dead;
    parse_word_t       due_q [$];
    parse_word_t       got_w;
    parse_word_t       exp_w;
    bit                has_word;

    function automatic char_class_t class_of(input logic [7:0] c);
        if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]})
            return CC_LETTER;
        if (c inside {[8'h30:8'h39]})
            return CC_DIGIT;
        if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
            return CC_BLANK;
        return CC_OTHER;
    endfunction

    function automatic logic [LINE_W-1:0] bump_line(input logic [LINE_W-1:0] n);
        return (n == LINE_MAX) ? n : n + 1'b1;
    endfunction

    task automatic parse_byte(input logic [7:0] c, output bit has, output parse_word_t w);
        char_class_t cc;
        bit          key_take;
        bit          val_take;
        bit          faulty;
        err_t        fault;
        cc       = class_of(c);
        key_take = 1'b0;
        val_take = 1'b0;
        faulty   = 1'b0;
        fault    = ERR_EXPECTED_KEY;
        has      = 1'b0;
        w.kind   = KIND_KEY;
        w.data   = c;
        w.code   = ERR_EXPECTED_KEY;
        w.line   = line_no;
        if (!dead)
        begin
            case (mode)
                MODE_COMMENT:
                    if (c == CH_NEWLINE)
                    begin
                        mode    = MODE_WAIT_KEY;
                        line_no = bump_line(line_no);
                    end
                MODE_READ_KEY:
                    if (c == CH_EQUALS)
                        mode = MODE_WAIT_VALUE;
                    else if (cc == CC_BLANK)
                        mode = MODE_WAIT_EQ;
                    else if (c == CH_NEWLINE)
                    begin
                        faulty = 1'b1;
                        fault  = ERR_NEWLINE_IN_KEY;
                    end
                    else if (cc == CC_OTHER)
                    begin
                        faulty = 1'b1;
                        fault  = ERR_BAD_KEY_CHAR;
                    end
                    else
                        key_take = 1'b1;
                MODE_WAIT_EQ:
                    if (c == CH_EQUALS)
                        mode = MODE_WAIT_VALUE;
                    else if (cc != CC_BLANK)
                    begin
                        faulty = 1'b1;
                        fault  = ERR_EXPECTED_EQ;
                    end
                MODE_WAIT_VALUE:
                    if (cc == CC_LETTER || cc == CC_DIGIT)
                    begin
                        mode     = MODE_READ_VALUE;
                        val_take = 1'b1;
                    end
                    else if (cc != CC_BLANK)
                    begin
                        faulty = 1'b1;
                        fault  = ERR_EXPECTED_VALUE;
                    end
                MODE_READ_VALUE:
                    if (c == CH_NEWLINE)
                    begin
                        mode    = MODE_WAIT_KEY;
                        key_len = '0;
                        val_len = '0;
                        line_no = bump_line(line_no);
                        has     = 1'b1;
                        w.kind  = KIND_PAIR;
                    end
                    else
                        val_take = 1'b1;
                default:
                begin
                    // waiting for a key; unknown codes fall back to waiting for a key too
                    mode = MODE_WAIT_KEY;
                    if (c == CH_HASH)
                        mode = MODE_COMMENT;
                    else if (c == CH_NEWLINE)
                        line_no = bump_line(line_no);
                    else if (cc == CC_LETTER)
                    begin
                        mode     = MODE_READ_KEY;
                        key_take = 1'b1;
                    end
                    else if (cc != CC_BLANK)
                    begin
                        faulty = 1'b1;
                        fault  = ERR_EXPECTED_KEY;
                    end
                end
            endcase
            if (key_take)
            begin
                key_len = key_len + 1'b1;
                has     = 1'b1;
                if (key_len == KEY_VALUE_MAX - 2)
                begin
                    faulty = 1'b1;
                    fault  = ERR_KEY_TOO_LONG;
                end
            end
            if (val_take)
            begin
                val_len = val_len + 1'b1;
                has     = 1'b1;
                w.kind  = KIND_VALUE;
                if (val_len == KEY_VALUE_MAX - 2)
                begin
                    faulty = 1'b1;
                    fault  = ERR_VALUE_TOO_LONG;
                end
            end
            if (faulty)
            begin
                has    = 1'b1;
                dead   = 1'b1;
                w.kind = KIND_ERROR;
                w.code = fault;
            end
            if (w.kind == KIND_PAIR || w.kind == KIND_ERROR)
                w.data = '0;
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode    = MODE_WAIT_KEY;
            key_len = '0;
            val_len = '0;
            line_no = LINE_FIRST;
            dead    = 1'b0;
            due_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_byte(text_byte, has_word, got_w);
                if (has_word)
                    due_q.push_back(got_w);
            end
            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual kind %0d line %0d",
                             $time, kind, line_number);
                end
                else
                begin
                    exp_w = due_q.pop_front();
                    if (kind !== exp_w.kind)
                    begin
                        mismatches++;
                        $display("%0t: kind: expected %0d actual %0d",
                                 $time, exp_w.kind, kind);
                    end
                    if (data_byte !== exp_w.data)
                    begin
                        mismatches++;
                        $display("%0t: data_byte: expected %02h actual %02h",
                                 $time, exp_w.data, data_byte);
                    end
                    if (error_code !== exp_w.code)
                    begin
                        mismatches++;
                        $display("%0t: error_code: expected %0d actual %0d",
                                 $time, exp_w.code, error_code);
                    end
                    if (line_number !== exp_w.line)
                    begin
                        mismatches++;
                        $display("%0t: line_number: expected %0d actual %0d",
                                 $time, exp_w.line, line_number);
                    end
                end
            end
        end
        words_due = due_q.size();
    end

endmodule

// ===== dv/tb_key_value_line_parser.sv =====
`timescale 1ns / 1ps
// tb_key_value_line_parser: drives text bytes and output stalls into the parser
// and gives the verdict; depends on kvlp_pkg, key_value_line_parser, kvlp_parse_check
module tb_key_value_line_parser;

    import kvlp_pkg::*;

    localparam int LEN_OK = KEY_VALUE_MAX_DEF - 3;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_ready;
    logic [7:0]        text_byte  = 8'h00;
    logic              out_valid;
    logic              out_ready  = 1'b0;
    logic [1:0]        kind;
    logic [7:0]        data_byte;
    logic [2:0]        error_code;
    logic [LINE_W-1:0] line_number;
    int                mismatches;
    int                words_due;

    int                calm_items = 0;
    int                ready_hold = 0;
    int                sent       = 0;
    err_t              breaker;

    key_value_line_parser DUT (.*);

    kvlp_parse_check u_check (.*);

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, LEN_OK);
        return $urandom_range(1, 8);
    endfunction

    function automatic logic [7:0] rand_alnum(input bit letters_only);
        int r;
        r = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
        if (r < 26)
            return 8'h41 + 8'(r);
        if (r < 52)
            return 8'h61 + 8'(r - 26);
        return 8'h30 + 8'(r - 52);
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_free();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_NEWLINE);
        return b;
    endfunction

    // a byte that is no letter, digit, blank, newline, hash or equals
    function automatic logic [7:0] rand_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]} ||
               b inside {CH_SPACE, CH_TAB, CH_CR, CH_NEWLINE, CH_HASH, CH_EQUALS});
        return b;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (calm_items > 0)
            calm_items--;
        else if ($urandom_range(0, 149) == 0)
            calm_items = $urandom_range(30, 120);
        else
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    task automatic send_blanks(input int most);
        repeat ($urandom_range(0, most)) send_byte(rand_blank());
    endtask

    task automatic send_key(input int n);
        send_byte(rand_alnum(1'b1));
        repeat (n - 1) send_byte(rand_alnum(1'b0));
    endtask

    task automatic send_pair(input int klen, input int vlen);
        send_blanks(2);
        send_key(klen);
        send_blanks(2);
        send_byte(CH_EQUALS);
        send_blanks(2);
        send_byte(rand_alnum(1'b0));
        repeat (vlen - 1) send_byte(rand_free());
        send_byte(CH_NEWLINE);
    endtask

    task automatic send_comment();
        send_blanks(2);
        send_byte(CH_HASH);
        repeat ($urandom_range(0, 20)) send_byte(rand_free());
        send_byte(CH_NEWLINE);
    endtask

    // output stalls: short ones mostly, long ones now and then
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if (out_ready)
        begin
            out_ready  <= 1'b0;
            ready_hold = pick_gap();
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300)
                                                       : $urandom_range(0, 8);
        end
    end

    initial
    begin
        logic [7:0] intro [$];
        intro = '{CH_HASH, CH_NEWLINE,
                  CH_SPACE, "A", "9", CH_TAB, CH_EQUALS, "0", CH_HASH, CH_SPACE, CH_CR,
                  8'h00, 8'h80, 8'hFF, CH_NEWLINE,
                  "z", CH_EQUALS, "Z", CH_NEWLINE,
                  CH_CR, CH_NEWLINE,
                  "a", CH_SPACE, CH_EQUALS, CH_TAB, "x", CH_NEWLINE};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (intro[i])
            send_byte(intro[i]);

        while (sent < 1900)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: send_pair(pick_len(), pick_len());
                6, 7:             send_comment();
                default:
                begin
                    send_blanks(3);
                    send_byte(CH_NEWLINE);
                end
            endcase
        end

        send_pair(3, 4);
        send_comment();
        send_pair(pick_len(), pick_len());

        // one error per run, then bytes the parser must ignore
        breaker = err_t'($urandom_range(0, 6));
        send_blanks(2);
        case (breaker)
            ERR_EXPECTED_KEY:
                case ($urandom_range(0, 2))
                    0:       send_byte(rand_junk());
                    1:       send_byte(CH_EQUALS);
                    default: send_byte(8'h30 + 8'($urandom_range(0, 9)));
                endcase
            ERR_NEWLINE_IN_KEY:
            begin
                send_key($urandom_range(1, 5));
                send_byte(CH_NEWLINE);
            end
            ERR_BAD_KEY_CHAR:
            begin
                send_key($urandom_range(1, 5));
                send_byte($urandom_range(0, 3) == 0 ? CH_HASH : rand_junk());
            end
            ERR_KEY_TOO_LONG:
                send_key(KEY_VALUE_MAX_DEF - 2);
            ERR_EXPECTED_EQ:
            begin
                send_key($urandom_range(1, 5));
                send_byte(rand_blank());
                send_blanks(2);
                case ($urandom_range(0, 2))
                    0:       send_byte(rand_junk());
                    1:       send_byte(CH_NEWLINE);
                    default: send_byte(rand_alnum(1'b0));
                endcase
            end
            ERR_EXPECTED_VALUE:
            begin
                send_key($urandom_range(1, 5));
                send_byte(CH_EQUALS);
                send_blanks(2);
                send_byte($urandom_range(0, 1) ? CH_NEWLINE : rand_junk());
            end
            default:
            begin
                send_key($urandom_range(1, 5));
                send_byte(CH_EQUALS);
                send_byte(rand_alnum(1'b0));
                repeat (KEY_VALUE_MAX_DEF - 3) send_byte(rand_free());
            end
        endcase
        repeat (16) send_byte(8'($urandom_range(0, 255)));
        in_valid <= 1'b0;

        do
            @(negedge clk);
        while (words_due != 0);
        repeat (10) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
